// ===== rtl/wacrms_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and control types of the windowed AC RMS meter.
package wacrms_pkg;

	// Default structural parameters of the top level.
	localparam int DEF_MAX_WINDOW  = 4096;
	localparam int DEF_SAMPLE_BITS = 12;

	// Configuration port geometry.
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	// Fixed field widths and fixed-point formats.
	localparam int WLEN_W     = 13;
	localparam int GAIN_W     = 16;
	localparam int FRAC_SHIFT = 16;
	localparam int CODE_W     = 16;
	localparam int INST_W     = 17;
	localparam int Q_FRAC     = 4;
	localparam int VAR_FRAC   = 8;

	// Reset values.
	localparam logic [WLEN_W-1:0] WLEN_RESET   = 13'd1000;
	localparam logic [CODE_W-1:0] OFFSET_RESET = 16'h8000;

	// Register indexes on the configuration port; the last one decodes to nothing.
	typedef enum logic [1:0] {
		REG_WINDOW    = 2'd0,
		REG_RMS_GAIN  = 2'd1,
		REG_INST_GAIN = 2'd2,
		REG_SPARE     = 2'd3
	} reg_idx_t;

	// Operations of the serial arithmetic unit.
	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} arith_op_t;

	// Command from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic      start;
		arith_op_t op;
	} au_ctrl_t;

endpackage

// ===== rtl/wacrms_arith.sv =====
`timescale 1ns / 1ps
// Bit-serial arithmetic unit: shift-add multiply, restoring divide and square root.
module wacrms_arith import wacrms_pkg::*; #(
	parameter int W      = 64,
	parameter int STEP_W = $clog2(W + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  au_ctrl_t          ctrl,
	input  logic [STEP_W-1:0] steps,
	input  logic [W-1:0]      opa,
	input  logic [W-1:0]      opb,
	output logic              done,
	output logic [W-1:0]      result
);

	logic              busy_q;
	logic [STEP_W-1:0] steps_q;
	arith_op_t         op_q;
	logic [W-1:0]      a_q;
	logic [W-1:0]      b_q;
	logic [W-1:0]      r_q;

	logic [W-1:0] a_d;
	logic [W-1:0] b_d;
	logic [W-1:0] r_d;
	logic [W-1:0] rem_sh;
	logic [W-1:0] trial;
	logic         ge;

	// One bit of the current operation per cycle.
	// Multiply: a is the shifting multiplicand, b the multiplier, r the accumulator.
	// Divide: a is the remainder, b the aligned divisor, r the quotient.
	// Square root: a is the remainder, b the radicand (two bits per step), r the root.
	always_comb begin
		rem_sh = {a_q[W-3:0], b_q[W-1:W-2]};
		trial  = {r_q[W-3:0], 2'b01};
		ge     = 1'b0;
		a_d    = a_q;
		b_d    = b_q;
		r_d    = r_q;
		case (op_q)
			OP_MUL: begin
				a_d = a_q << 1;
				b_d = b_q >> 1;
				r_d = b_q[0] ? r_q + a_q : r_q;
			end
			OP_DIV: begin
				ge  = a_q >= b_q;
				a_d = ge ? a_q - b_q : a_q;
				b_d = b_q >> 1;
				r_d = {r_q[W-2:0], ge};
			end
			OP_SQRT: begin
				ge  = rem_sh >= trial;
				a_d = ge ? rem_sh - trial : rem_sh;
				b_d = b_q << 2;
				r_d = {r_q[W-2:0], ge};
			end
			default: begin
				a_d = a_q;
			end
		endcase
	end

	// A new command always wins; otherwise step until the counter runs out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			steps_q <= '0;
			op_q    <= OP_MUL;
			a_q     <= '0;
			b_q     <= '0;
			r_q     <= '0;
		end else if (ctrl.start) begin
			busy_q  <= 1'b1;
			steps_q <= steps;
			op_q    <= ctrl.op;
			a_q     <= opa;
			b_q     <= opb;
			r_q     <= '0;
		end else if (busy_q && steps_q != '0) begin
			steps_q <= steps_q - STEP_W'(1);
			a_q     <= a_d;
			b_q     <= b_d;
			r_q     <= r_d;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign done   = busy_q && (steps_q == '0);
	assign result = r_q;

endmodule

// ===== rtl/windowed_ac_rms_meter_core.sv =====
`timescale 1ns / 1ps
// Top level of the windowed AC RMS meter: sequencer, accumulators, registers and output stage.
//
// Usage: each transaction on the sample channel (sample_valid/sample_ready) carries one raw
// ADC code. For every sample one transaction leaves on the result channel
// (result_valid/result_ready): the offset-removed, gain-scaled instantaneous value, the held
// RMS value, a flag that marks the sample that closed a window, and the current DC offset.
// Registers sit on an APB-style port: window_length at 0x0, rms_gain at 0x4, instant_gain at
// 0x8; pready is always high. Write them only while the block is idle.
// Timing: all arithmetic runs through one bit-serial unit that retires one bit per cycle.
// A sample that does not close a window takes the square and the instantaneous scaling; the
// next sample can be accepted as soon as its result enters the output register. A closing
// sample adds the window multiplies, the variance and offset divisions, the square root and
// the RMS scaling. One sample is processed at a time; sample_ready is high whenever the
// sequencer is idle.
// Reset clears the sums and count, sets the offset to half scale, the held RMS to zero and
// the registers to their defaults; no result is pending after reset.
// Stall: one finished result waits in the output register; the next sample is still taken
// and processed, and its result waits in the sequencer until the output register frees.
module windowed_ac_rms_meter_core import wacrms_pkg::*; #(
	parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// Sample channel.
	input  logic                     sample_valid,
	output logic                     sample_ready,
	input  logic [SAMPLE_BITS-1:0]   sample,
	// Result channel.
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic signed [INST_W-1:0] instant_value,
	output logic [CODE_W-1:0]        rms_value,
	output logic                     rms_updated,
	output logic [CODE_W-1:0]        dc_offset,
	// Configuration port.
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [CFG_ADDR_W-1:0]    paddr,
	input  logic [CFG_DATA_W-1:0]    pwdata,
	output logic [CFG_DATA_W-1:0]    prdata,
	output logic                     pready
);

	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W   = SAMPLE_BITS + CNT_W;
	localparam int SQ_W    = 2 * SAMPLE_BITS + CNT_W;
	localparam int RT_W    = SAMPLE_BITS + Q_FRAC;
	localparam int VQ_W    = 2 * RT_W;
	localparam int DIF_W   = ((SAMPLE_BITS + Q_FRAC > CODE_W) ? SAMPLE_BITS + Q_FRAC : CODE_W) + 1;
	localparam int AU_BASE = 2 * SAMPLE_BITS + 2 * CNT_W + VAR_FRAC;
	localparam int AU_PROD = DIF_W + GAIN_W;
	localparam int AU_W    = (AU_BASE > AU_PROD) ? AU_BASE : AU_PROD;
	localparam int STEP_W  = $clog2(AU_W + 1);

	localparam logic [STEP_W-1:0] STEPS_SQR  = STEP_W'(SAMPLE_BITS);
	localparam logic [STEP_W-1:0] STEPS_CNT  = STEP_W'(CNT_W);
	localparam logic [STEP_W-1:0] STEPS_SUM  = STEP_W'(SUM_W);
	localparam logic [STEP_W-1:0] STEPS_VAR  = STEP_W'(VQ_W);
	localparam logic [STEP_W-1:0] STEPS_RT   = STEP_W'(RT_W);
	localparam logic [STEP_W-1:0] STEPS_GAIN = STEP_W'(GAIN_W);

	// Sequencer states, one-hot.
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SQR   = 11'b000_0000_0010,
		ST_MNQ   = 11'b000_0000_0100,
		ST_MSS   = 11'b000_0000_1000,
		ST_MNN   = 11'b000_0001_0000,
		ST_DVAR  = 11'b000_0010_0000,
		ST_DOFF  = 11'b000_0100_0000,
		ST_SQRT  = 11'b000_1000_0000,
		ST_MRMS  = 11'b001_0000_0000,
		ST_MINST = 11'b010_0000_0000,
		ST_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [WLEN_W-1:0] wl_q;
	logic [GAIN_W-1:0] rgain_q;
	logic [GAIN_W-1:0] igain_q;
	reg_idx_t          cfg_idx;
	logic              cfg_wr;

	// Window state and working registers.
	logic [SAMPLE_BITS-1:0] x_q;
	logic [SUM_W-1:0]       sum_q;
	logic [SQ_W-1:0]        sq_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [CODE_W-1:0]      offset_q;
	logic [CODE_W-1:0]      held_q;
	logic [AU_W-1:0]        tmp_q;
	logic                   closed_q;
	logic [INST_W-1:0]      inst_q;

	// Output register.
	logic                   rv_q;
	logic [INST_W-1:0]      out_inst_q;
	logic [CODE_W-1:0]      out_rms_q;
	logic                   out_upd_q;
	logic [CODE_W-1:0]      out_off_q;

	// Arithmetic unit interface.
	au_ctrl_t          au_ctrl;
	logic [STEP_W-1:0] au_steps;
	logic [AU_W-1:0]   au_a;
	logic [AU_W-1:0]   au_b;
	logic              au_done;
	logic [AU_W-1:0]   au_res;

	// Combinational helpers.
	logic [CNT_W-1:0] eff_c;
	logic [SUM_W-1:0] sum_new;
	logic [SQ_W-1:0]  sq_new;
	logic [CNT_W-1:0] cnt_new;
	logic             close_c;
	logic [AU_W-1:0]  num_c;
	logic [DIF_W-1:0] xs_c;
	logic [DIF_W-1:0] off_c;
	logic [DIF_W-1:0] diff_c;
	logic [AU_W-1:0]  diff_ext;
	logic             out_free;

	// Configuration port: writes complete in the access phase, reads return the register.
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q    <= WLEN_RESET;
			rgain_q <= '0;
			igain_q <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WINDOW:    wl_q    <= pwdata[WLEN_W-1:0];
				REG_RMS_GAIN:  rgain_q <= pwdata[GAIN_W-1:0];
				REG_INST_GAIN: igain_q <= pwdata[GAIN_W-1:0];
				default: begin
					wl_q <= wl_q;
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WINDOW:    prdata = CFG_DATA_W'(wl_q);
			REG_RMS_GAIN:  prdata = CFG_DATA_W'(rgain_q);
			REG_INST_GAIN: prdata = CFG_DATA_W'(igain_q);
			default:       prdata = '0;
		endcase
	end

	// Effective window: zero means one sample, and the length saturates at MAX_WINDOW.
	always_comb begin
		if (wl_q == '0) begin
			eff_c = CNT_W'(1);
		end else if (32'(wl_q) > MAX_WINDOW) begin
			eff_c = CNT_W'(MAX_WINDOW);
		end else begin
			eff_c = CNT_W'(wl_q);
		end
	end

	// Accumulator update after the square, the clamped variance numerator and the offset removal.
	assign sum_new  = sum_q + SUM_W'(x_q);
	assign sq_new   = sq_q + SQ_W'(au_res[2*SAMPLE_BITS-1:0]);
	assign cnt_new  = cnt_q + CNT_W'(1);
	assign close_c  = cnt_new >= eff_c;
	assign num_c    = (tmp_q > au_res) ? tmp_q - au_res : '0;
	assign xs_c     = DIF_W'({x_q, {Q_FRAC{1'b0}}});
	assign off_c    = DIF_W'(offset_q);
	assign diff_c   = xs_c - off_c;
	assign diff_ext = {{(AU_W-DIF_W){diff_c[DIF_W-1]}}, diff_c};
	assign out_free = !rv_q || result_ready;

	// Arithmetic unit commands: on a new sample in idle, else in the cycle the last operation finishes.
	always_comb begin
		au_ctrl  = '{start: 1'b0, op: OP_MUL};
		au_steps = '0;
		au_a     = '0;
		au_b     = '0;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					au_ctrl  = '{start: 1'b1, op: OP_MUL};
					au_steps = STEPS_SQR;
					au_a     = AU_W'(sample);
					au_b     = AU_W'(sample);
				end
			end
			ST_SQR: begin
				if (au_done && close_c) begin
					au_ctrl  = '{start: 1'b1, op: OP_MUL};
					au_steps = STEPS_CNT;
					au_a     = AU_W'(sq_new);
					au_b     = AU_W'(cnt_new);
				end else if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_MUL};
					au_steps = STEPS_GAIN;
					au_a     = diff_ext;
					au_b     = AU_W'(igain_q);
				end
			end
			ST_MNQ: begin
				if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_MUL};
					au_steps = STEPS_SUM;
					au_a     = AU_W'(sum_q);
					au_b     = AU_W'(sum_q);
				end
			end
			ST_MSS: begin
				if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_MUL};
					au_steps = STEPS_CNT;
					au_a     = AU_W'(cnt_q);
					au_b     = AU_W'(cnt_q);
				end
			end
			ST_MNN: begin
				// Variance in Q.8: numerator over the squared count.
				if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_DIV};
					au_steps = STEPS_VAR;
					au_a     = tmp_q;
					au_b     = au_res << (VQ_W - 1);
				end
			end
			ST_DVAR: begin
				// Mean in Q12.4 becomes the new offset.
				if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_DIV};
					au_steps = STEPS_RT;
					au_a     = AU_W'(sum_q) << Q_FRAC;
					au_b     = AU_W'(cnt_q) << (RT_W - 1);
				end
			end
			ST_DOFF: begin
				if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_SQRT};
					au_steps = STEPS_RT;
					au_a     = '0;
					au_b     = tmp_q << (AU_W - VQ_W);
				end
			end
			ST_SQRT: begin
				if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_MUL};
					au_steps = STEPS_GAIN;
					au_a     = au_res;
					au_b     = AU_W'(rgain_q);
				end
			end
			ST_MRMS: begin
				if (au_done) begin
					au_ctrl  = '{start: 1'b1, op: OP_MUL};
					au_steps = STEPS_GAIN;
					au_a     = diff_ext;
					au_b     = AU_W'(igain_q);
				end
			end
			default: begin
				au_steps = '0;
			end
		endcase
	end

	wacrms_arith #(
		.W      (AU_W),
		.STEP_W (STEP_W)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (au_ctrl),
		.steps  (au_steps),
		.opa    (au_a),
		.opb    (au_b),
		.done   (au_done),
		.result (au_res)
	);

	// Sequencer, window state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			x_q        <= '0;
			sum_q      <= '0;
			sq_q       <= '0;
			cnt_q      <= '0;
			offset_q   <= OFFSET_RESET;
			held_q     <= '0;
			tmp_q      <= '0;
			closed_q   <= 1'b0;
			inst_q     <= '0;
			rv_q       <= 1'b0;
			out_inst_q <= '0;
			out_rms_q  <= '0;
			out_upd_q  <= 1'b0;
			out_off_q  <= '0;
		end else begin
			// A taken result frees the output register unless a new one is loaded now.
			if (rv_q && result_ready && state_q != ST_OUT) begin
				rv_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						x_q     <= sample;
						state_q <= ST_SQR;
					end
				end
				ST_SQR: begin
					if (au_done) begin
						sum_q    <= sum_new;
						sq_q     <= sq_new;
						cnt_q    <= cnt_new;
						closed_q <= close_c;
						state_q  <= close_c ? ST_MNQ : ST_MINST;
					end
				end
				ST_MNQ: begin
					if (au_done) begin
						tmp_q   <= au_res;
						state_q <= ST_MSS;
					end
				end
				ST_MSS: begin
					if (au_done) begin
						tmp_q   <= num_c << VAR_FRAC;
						state_q <= ST_MNN;
					end
				end
				ST_MNN: begin
					if (au_done) begin
						state_q <= ST_DVAR;
					end
				end
				ST_DVAR: begin
					if (au_done) begin
						tmp_q   <= au_res;
						state_q <= ST_DOFF;
					end
				end
				ST_DOFF: begin
					// New offset is in place; the window restarts.
					if (au_done) begin
						offset_q <= au_res[CODE_W-1:0];
						sum_q    <= '0;
						sq_q     <= '0;
						cnt_q    <= '0;
						state_q  <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					if (au_done) begin
						state_q <= ST_MRMS;
					end
				end
				ST_MRMS: begin
					if (au_done) begin
						held_q  <= au_res[FRAC_SHIFT +: CODE_W];
						state_q <= ST_MINST;
					end
				end
				ST_MINST: begin
					if (au_done) begin
						inst_q  <= au_res[FRAC_SHIFT +: INST_W];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						rv_q       <= 1'b1;
						out_inst_q <= inst_q;
						out_rms_q  <= held_q;
						out_upd_q  <= closed_q;
						out_off_q  <= offset_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign sample_ready  = (state_q == ST_IDLE);
	assign result_valid  = rv_q;
	assign instant_value = $signed(out_inst_q);
	assign rms_value     = out_rms_q;
	assign rms_updated   = out_upd_q;
	assign dc_offset     = out_off_q;

	// A taken result empties the output register unless a new one is loaded in the same cycle.
	a_result_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(rv_q && result_ready && state_q != ST_OUT) |=> !rv_q)
		else $error("output register did not drain after a transaction");

	// The arithmetic unit only finishes while the sequencer waits for it.
	a_done_in_compute: assert property (@(posedge clk) disable iff (!arst_n)
		au_done |-> !(state_q == ST_IDLE || state_q == ST_OUT))
		else $error("arithmetic unit finished outside a compute state");

	// The held RMS value changes only at the end of the RMS scaling.
	a_held_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(held_q) |-> $past(state_q == ST_MRMS && au_done))
		else $error("held RMS changed outside a window close");

	// Closing a window restarts the count.
	a_window_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DOFF && au_done) |=> (cnt_q == '0))
		else $error("sample count not cleared after a window close");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the windowed AC RMS meter core with a sample-level meter predictor.
module tb import wacrms_pkg::*; ();

	localparam int SAMPLE_W    = DEF_SAMPLE_BITS;
	localparam int MAX_WIN     = DEF_MAX_WINDOW;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 300;
	localparam int LONG_WIN    = 400;
	localparam longint LIMIT_CYCLES = 4_000_000;

	// One result of the meter as the predictor expects it.
	typedef struct {
		logic signed [INST_W-1:0] inst;
		logic [CODE_W-1:0]        rms;
		logic                     updated;
		logic [CODE_W-1:0]        offset;
	} meter_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic [SAMPLE_W-1:0] sample = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic signed [INST_W-1:0] instant_value;
	logic [CODE_W-1:0] rms_value;
	logic rms_updated;
	logic [CODE_W-1:0] dc_offset;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic pready;

	windowed_ac_rms_meter_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.instant_value(instant_value),
		.rms_value(rms_value),
		.rms_updated(rms_updated),
		.dc_offset(dc_offset),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Predictor copy of the registers and of the window state.
	logic [WLEN_W-1:0] m_window = WLEN_RESET;
	logic [GAIN_W-1:0] m_rms_gain = '0;
	logic [GAIN_W-1:0] m_inst_gain = '0;
	longint unsigned acc_sum = 0;
	longint unsigned acc_sq = 0;
	longint unsigned acc_cnt = 0;
	logic [CODE_W-1:0] ofs_code = OFFSET_RESET;
	logic [CODE_W-1:0] rms_hold = '0;

	meter_result_t expected_results[$];
	int errors = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int windows_closed = 0;
	int src_gap_pct = 0;
	int snk_stall_pct = 0;
	int seq_center = 2048;
	longint cycles = 0;
	logic hold_toggle = 1'b0;
	logic hold_ack = 1'b0;
	int hold_left = 0;

	// Clock generation.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Floor of the square root, one result bit at a time.
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned r = 0;
		longint unsigned b;
		for (int i = 31; i >= 0; i--) begin
			b = r | (64'd1 << i);
			if (b * b <= v)
				r = b;
		end
		return r;
	endfunction

	// Advance the meter state by one sample and return the result it should emit.
	function automatic meter_result_t predict_meter(input logic [SAMPLE_W-1:0] x);
		meter_result_t r;
		longint unsigned eff, n, sq, ns, num, var256, rms_q, scaled;
		longint d, p, q;
		acc_sum += x;
		acc_sq += longint'(x) * longint'(x);
		acc_cnt += 1;
		eff = (m_window == 0) ? 1 : ((m_window > MAX_WIN) ? MAX_WIN : m_window);
		r.updated = 1'b0;
		if (acc_cnt >= eff) begin
			// Window close: exact variance, clamped at zero, then offset and scaled RMS.
			n = acc_cnt;
			sq = acc_sum * acc_sum;
			ns = n * acc_sq;
			num = (ns > sq) ? (ns - sq) : 0;
			var256 = (num * 256) / (n * n);
			rms_q = floor_sqrt(var256);
			scaled = (acc_sum * 16) / n;
			ofs_code = scaled[CODE_W-1:0];
			scaled = (rms_q * m_rms_gain) >> 16;
			rms_hold = scaled[CODE_W-1:0];
			acc_sum = 0;
			acc_sq = 0;
			acc_cnt = 0;
			r.updated = 1'b1;
		end
		// Offset-removed value; the arithmetic shift floors negative products.
		d = longint'(x) * 16 - longint'(ofs_code);
		p = d * longint'(m_inst_gain);
		q = p >>> 16;
		r.inst = q[INST_W-1:0];
		r.rms = rms_hold;
		r.offset = ofs_code;
		return r;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] reg_value(input reg_idx_t a);
		case (a)
			REG_WINDOW:    return CFG_DATA_W'(m_window);
			REG_RMS_GAIN:  return CFG_DATA_W'(m_rms_gain);
			REG_INST_GAIN: return CFG_DATA_W'(m_inst_gain);
			default:       return '0;
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 20)
			return '1;
		return GAIN_W'($urandom);
	endfunction

	// Uniform codes, rail values, or a low-variance cluster around the segment center.
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int r;
		int v;
		r = $urandom_range(99);
		if (r < 50)
			return SAMPLE_W'($urandom_range(4095));
		if (r < 70)
			return $urandom_range(1) ? SAMPLE_W'(4095) : SAMPLE_W'(0);
		v = seq_center + $urandom_range(100) - 50;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return SAMPLE_W'(v);
	endfunction

	// Register write: setup phase, access phase, then a return to bus idle.
	task automatic write_reg(input reg_idx_t a, input logic [CFG_DATA_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {a, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (a)
			REG_WINDOW:    m_window = v[WLEN_W-1:0];
			REG_RMS_GAIN:  m_rms_gain = v[GAIN_W-1:0];
			REG_INST_GAIN: m_inst_gain = v[GAIN_W-1:0];
			default:       ;
		endcase
		@(posedge clk);
	endtask

	// Reads every known register back and compares it with the predictor copy.
	task automatic check_regs();
		reg_idx_t a;
		for (int i = 0; i < 3; i++) begin
			a = (i == 0) ? REG_WINDOW : ((i == 1) ? REG_RMS_GAIN : REG_INST_GAIN);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= {a, 2'b00};
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== reg_value(a)) begin
				$error("prdata mismatch at 0x%0h: expected 0x%0h, got 0x%0h",
					{a, 2'b00}, reg_value(a), prdata);
				errors++;
			end
			psel <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Gains and window with random filler in the unused data bits, then a register read-back.
	task automatic set_config(input logic [WLEN_W-1:0] win, input logic [GAIN_W-1:0] rg,
			input logic [GAIN_W-1:0] ig);
		write_reg(REG_WINDOW, ($urandom & ~32'h1FFF) | 32'(win));
		write_reg(REG_RMS_GAIN, ($urandom & 32'hFFFF_0000) | 32'(rg));
		write_reg(REG_INST_GAIN, ($urandom & 32'hFFFF_0000) | 32'(ig));
		check_regs();
	endtask

	// Sends one sample transaction, with random gaps before it.
	task automatic send_sample(input logic [SAMPLE_W-1:0] x);
		while ($urandom_range(99) < src_gap_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= x;
		do @(posedge clk); while (!sample_ready);
		expected_results.push_back(predict_meter(x));
		samples_sent++;
	endtask

	// Waits until every expected result has been taken and the block is quiet.
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Result checking against the predictor queue.
	always @(posedge clk) begin
		meter_result_t e;
		if (result_valid && result_ready) begin
			results_seen++;
			if (rms_updated === 1'b1)
				windows_closed++;
			if (expected_results.size() == 0) begin
				$error("result transaction with no expected result pending");
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (instant_value !== e.inst) begin
					$error("instant_value mismatch: expected %0d, got %0d", e.inst, instant_value);
					errors++;
				end
				if (rms_value !== e.rms) begin
					$error("rms_value mismatch: expected %0d, got %0d", e.rms, rms_value);
					errors++;
				end
				if (rms_updated !== e.updated) begin
					$error("rms_updated mismatch: expected %0d, got %0d", e.updated, rms_updated);
					errors++;
				end
				if (dc_offset !== e.offset) begin
					$error("dc_offset mismatch: expected %0d, got %0d", e.offset, dc_offset);
					errors++;
				end
			end
		end
	end

	// Receiver readiness: random stalls, or a long hold counted down in cycles.
	always @(posedge clk) begin
		if (hold_toggle != hold_ack) begin
			hold_ack <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Reset values of the registers and a few samples with zero gains.
	task automatic test_register_defaults();
		check_regs();
		send_sample(12'd2048);
		send_sample(12'd0);
		send_sample(12'd4095);
		wait_idle();
	endtask

	// Rail codes, one- and two-sample windows, zero window and gain extremes.
	task automatic test_directed_corners();
		set_config(13'd1, 16'hFFFF, 16'hFFFF);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
		send_sample(12'd1);
		send_sample(12'd4094);
		wait_idle();
		// Largest possible variance over a two-sample window.
		set_config(13'd2, 16'hFFFF, 16'hFFFF);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd4095);
		send_sample(12'd0);
		wait_idle();
		// A zero window length behaves as one sample.
		set_config(13'd0, 16'h8000, 16'h0001);
		send_sample(12'd100);
		send_sample(12'd3000);
		wait_idle();
		set_config(13'd3, 16'h0001, 16'h0001);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd0);
		wait_idle();
	endtask

	// Window shortened below the running count, saturated window, and unknown register.
	task automatic test_window_shrink();
		set_config(13'd1000, pick_gain(), pick_gain());
		for (int i = 0; i < 5; i++)
			send_sample(pick_sample());
		wait_idle();
		set_config(13'd2, m_rms_gain, m_inst_gain);
		send_sample(12'd4095);
		wait_idle();
		set_config(13'h1FFF, 16'hFFFF, 16'h7FFF);
		for (int i = 0; i < 3; i++)
			send_sample(pick_sample());
		wait_idle();
		write_reg(REG_SPARE, $urandom);
		check_regs();
		write_reg(REG_WINDOW, 32'd1);
		send_sample(12'd17);
		wait_idle();
	endtask

	// One complete long window of mostly rail codes, so the sums grow large.
	task automatic test_full_window();
		src_gap_pct = 0;
		snk_stall_pct = 0;
		set_config(WLEN_W'(LONG_WIN), pick_gain(), pick_gain());
		for (int i = 0; i < LONG_WIN + 2; i++)
			send_sample($urandom_range(3) != 0 ? SAMPLE_W'(4095) : SAMPLE_W'($urandom_range(4095)));
		wait_idle();
	endtask

	// Random segments, each with its own window, gains and sample cluster.
	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int count);
		int left;
		int seg;
		int r;
		logic [WLEN_W-1:0] win;
		src_gap_pct = src_pct;
		snk_stall_pct = snk_pct;
		left = count;
		while (left > 0) begin
			r = $urandom_range(99);
			if (r < 5)
				win = '0;
			else if (r < 10)
				win = 13'd1;
			else if (r < 15)
				win = 13'h1FFF;
			else if (r < 70)
				win = WLEN_W'($urandom_range(32, 2));
			else if (r < 90)
				win = WLEN_W'($urandom_range(200, 33));
			else
				win = WLEN_W'($urandom_range(8191, 201));
			set_config(win, pick_gain(), pick_gain());
			if ($urandom_range(9) == 0) begin
				write_reg(REG_SPARE, $urandom);
				check_regs();
			end
			seq_center = $urandom_range(4095);
			seg = $urandom_range(120, 20);
			if (seg > left)
				seg = left;
			for (int i = 0; i < seg; i++)
				send_sample(pick_sample());
			left -= seg;
			wait_idle();
		end
	endtask

	// Receiver holds off for a long stretch while samples keep coming.
	task automatic test_output_hold();
		src_gap_pct = 0;
		snk_stall_pct = 0;
		set_config(13'd7, pick_gain(), pick_gain());
		hold_toggle <= ~hold_toggle;
		for (int i = 0; i < 40; i++)
			send_sample(pick_sample());
		wait_idle();
	endtask

	// Test sequence.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_defaults();
		test_directed_corners();
		test_window_shrink();
		test_full_window();
		test_random_traffic(0, 0, 300);
		test_random_traffic(70, 0, 300);
		test_random_traffic(0, 70, 300);
		test_random_traffic(33, 33, 300);
		test_output_hold();
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			errors++;
		end
		$display("Checked %0d results for %0d samples, %0d of them closing a window.",
			results_seen, samples_sent, windows_closed);
		$display("Covered rail codes, zero, shrunk, saturated and long windows, gain extremes, "
			, "four idling mixes and a long output hold.");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/wacrms_pkg.sv
rtl/wacrms_arith.sv
rtl/windowed_ac_rms_meter_core.sv
tb/tb.sv
